[hw/rtl/fractional_max_pool_3d_top_macros.svh]
// Assertion macros used by the fractional max pooling top level.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef FRACTIONAL_MAX_POOL_3D_TOP_MACROS_SVH
`define FRACTIONAL_MAX_POOL_3D_TOP_MACROS_SVH

// Same-cycle implication.
`define FRP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication.
`define FRP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

[hw/rtl/frp_pkg.sv]
// Package for the fractional max pooling block: widths, codes, state type,
// divider request and response types and float helpers. No dependencies.
`default_nettype none
package frp_pkg;
	localparam int AXIS_W      = 5;
	localparam int VAL_W       = 32;
	localparam int FRAC_W      = 16;
	localparam int IDX_W       = 12;
	localparam int STORE_DEPTH = 4096;
	localparam int MAX_AXIS    = 16;
	localparam int KM_W        = 3;
	localparam int DIV_W       = FRAC_W + AXIS_W;
	localparam int MUL_W       = DIV_W;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int HI_W        = PROD_W - 2 * FRAC_W;
	localparam int TOT_W       = 3 * AXIS_W;
	localparam int N12_W       = 2 * AXIS_W;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 9;
	localparam int DCNT_W      = $clog2(DIV_W + 1);

	typedef logic [1:0] func_t;
	localparam func_t FUNC_FRAC   = 2'd0;
	localparam func_t FUNC_LOAD   = 2'd1;
	localparam func_t FUNC_READ   = 2'd2;
	localparam func_t FUNC_UNUSED = 2'd3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_IN_T   = 3'd0;
	localparam cfg_idx_t CFG_IN_H   = 3'd1;
	localparam cfg_idx_t CFG_IN_W   = 3'd2;
	localparam cfg_idx_t CFG_OUT_T  = 3'd3;
	localparam cfg_idx_t CFG_OUT_H  = 3'd4;
	localparam cfg_idx_t CFG_OUT_W  = 3'd5;
	localparam cfg_idx_t CFG_WIN    = 3'd6;
	localparam cfg_idx_t CFG_FLOAT  = 3'd7;

	localparam logic [VAL_W-1:0] INT_LOWEST   = 32'h8000_0000;
	localparam logic [VAL_W-1:0] FLOAT_LOWEST = 32'hFF7F_FFFF;

	typedef enum logic [4:0] {
		S_IDLE, S_N12, S_TOT_A, S_TOT_B, S_WGO, S_WWT, S_HGO, S_HWT,
		S_AX_CHK, S_AGO, S_AWT, S_AX_MA, S_AX_MB, S_BASE_A, S_BASE_B,
		S_SCAN, S_DRAIN, S_EMIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [AXIS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_W-1:0]  quot;
		logic [AXIS_W-1:0] rem;
	} div_rsp_t;

	function automatic logic f_is_nan(input logic [VAL_W-1:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	// Maps float bits to an unsigned key whose order is the numeric order;
	// both zeros map to the same key.
	function automatic logic [VAL_W-1:0] f_key(input logic [VAL_W-1:0] b);
		logic [VAL_W-1:0] k;
		if (b[30:0] == 31'd0) k = 32'h8000_0000;
		else if (b[31]) k = ~b;
		else k = b | 32'h8000_0000;
		return k;
	endfunction
endpackage
`default_nettype wire

[hw/rtl/frp_in_if.sv]
// Input channel interface of the fractional max pooling block.
// Depends on frp_pkg.
`default_nettype none
interface frp_in_if import frp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic signed [VAL_W-1:0] voxel_value;
	logic [FRAC_W-1:0]   sample_t;
	logic [FRAC_W-1:0]   sample_h;
	logic [FRAC_W-1:0]   sample_w;
	modport source (output valid, func, voxel_value, sample_t, sample_h, sample_w,
		input ready);
	modport sink (input valid, func, voxel_value, sample_t, sample_h, sample_w,
		output ready);
endinterface
`default_nettype wire

[hw/rtl/frp_out_if.sv]
// Result channel interface of the fractional max pooling block.
// Depends on frp_pkg.
`default_nettype none
interface frp_out_if import frp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] max_value;
	logic [IDX_W-1:0]        max_index;
	logic                    last_of_plane;
	logic                    status;
	modport source (output valid, max_value, max_index, last_of_plane, status,
		input ready);
	modport sink (input valid, max_value, max_index, last_of_plane, status,
		output ready);
endinterface
`default_nettype wire

[hw/rtl/frp_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module frp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[hw/rtl/frp_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on frp_pkg.
`default_nettype none
module frp_div import frp_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output      div_rsp_t rsp
);
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q, done_q;
	logic [DIV_W-1:0]  num_q;
	logic [AXIS_W-1:0] rem_q, dvs_q;
	logic [AXIS_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, num_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_W-2:0], fits};
			rem_q <= fits ? AXIS_W'(trial - {1'b0, dvs_q}) : trial[AXIS_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = num_q;
	assign rsp.rem  = rem_q;
endmodule
`default_nettype wire

[hw/rtl/fractional_max_pool_3d_top.sv]
// Top level of the 3-D fractional max pooling block: sequencer, shared
// multiplier, serial divider and voxel store. Depends on frp_pkg, the
// channel interfaces, frp_div, frp_ram and the assertion macro header.
//
//   channel   dir   handshake        payload
//   in_ch     in    valid / ready    func, voxel_value, sample_t/h/w
//   out_ch    out   valid / ready    max_value, max_index, last_of_plane, status
//   cfg       in    cfg_we           cfg_index, cfg_data
//
// Fraction and voxel-load transfers are accepted only while the sequencer is idle.
// A read runs two 21-step divisions for the output coordinates and up to three
// more for the per-axis step, all on the one serial divider, then scans every
// window voxel (k_t*k_h*k_w, up to 512).
// The window scan is bound by the single read port of the voxel store.
// Reset clears the counters and fractions; datapath and store are not cleared.
// A finished result waits in the output register while new transfers go on.
`default_nettype none
`include "fractional_max_pool_3d_top_macros.svh"
module fractional_max_pool_3d_top import frp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	frp_in_if.sink                     in_ch,
	frp_out_if.source                  out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int AW = $clog2(STORE_DEPTH);

	state_t state_q, state_d;

	logic [AXIS_W-1:0] n_q [3];
	logic [AXIS_W-1:0] m_q [3];
	logic [CFG_DATA_W-1:0] win_q;
	logic              float_q;
	logic [FRAC_W-1:0] frac_q [3];
	logic [IDX_W-1:0]  load_cnt_q, out_cnt_q;

	logic [N12_W-1:0]  n12_q, m21_q;
	logic [TOT_W-1:0]  total_q;
	logic [IDX_W-1:0]  c_q, q1_q;
	logic [AXIS_W-1:0] o_q [3];
	logic [AXIS_W-1:0] st_q [3];
	logic [1:0]        ax_q;
	logic [DIV_W-1:0]  alpha_q;
	logic [HI_W-1:0]   a_q;
	logic [IDX_W-1:0]  base_q, tbase_q, hbase_q, addr_q;
	logic [KM_W-1:0]   kt_q, kh_q, kw_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [VAL_W-1:0]  best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              best_nan_q;
	logic              invalid_q;
	logic              out_valid_q;

	logic              in_fire, out_take, ok;
	logic [KM_W-1:0]   km [3];
	logic [AXIS_W-1:0] cur_n, cur_m, cur_o, top;
	logic [FRAC_W-1:0] cur_u;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] prod;
	logic [HI_W-1:0]   hi, diff;
	logic              ax_bypass, scan_last;
	logic [IDX_W-1:0]  base_next;
	logic [VAL_W-1:0]  rdata;
	logic              take;
	logic              ram_re;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_take = !out_valid_q || out_ch.ready;

	always_comb begin
		ok = 1'b1;
		for (int i = 0; i < 3; i++) begin
			km[i] = win_q[KM_W*i +: KM_W];
			if (m_q[i] == '0 || n_q[i] > AXIS_W'(MAX_AXIS) ||
				({1'b0, m_q[i]} + {3'b0, km[i]}) >= {1'b0, n_q[i]}) ok = 1'b0;
		end
	end

	assign cur_n = n_q[ax_q];
	assign cur_m = m_q[ax_q];
	assign cur_o = o_q[ax_q];
	assign cur_u = frac_q[ax_q];
	assign top   = AXIS_W'(cur_n - ({2'b0, km[ax_q]} + 1'b1));
	assign ax_bypass = (cur_m <= AXIS_W'(1)) || ((cur_o + 1'b1) >= cur_m);

	assign prod = mul_a * mul_b;
	assign hi   = prod[PROD_W-1 -: HI_W];
	assign diff = a_q - hi;
	assign base_next = base_q + prod[IDX_W-1:0] + IDX_W'(st_q[2]);
	assign scan_last = (kw_q == km[2]) && (kh_q == km[1]) && (kt_q == km[0]);

	// Float mode: a NaN always wins, also over a held NaN; no number beats a held NaN.
	always_comb begin
		if (float_q) begin
			if (f_is_nan(rdata)) take = 1'b1;
			else if (best_nan_q) take = 1'b0;
			else take = f_key(rdata) > f_key(best_q);
		end else begin
			take = $signed(rdata) > $signed(best_q);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_fire && in_ch.func == FUNC_READ) state_d = ok ? S_N12 : S_EMIT;
			S_N12:    state_d = S_TOT_A;
			S_TOT_A:  state_d = S_TOT_B;
			S_TOT_B:  state_d = S_WGO;
			S_WGO:    state_d = S_WWT;
			S_WWT:    if (div_rsp.done) state_d = S_HGO;
			S_HGO:    state_d = S_HWT;
			S_HWT:    if (div_rsp.done) state_d = S_AX_CHK;
			S_AX_CHK: begin
				if (!ax_bypass) state_d = S_AGO;
				else if (ax_q == 2'd2) state_d = S_BASE_A;
			end
			S_AGO:    state_d = S_AWT;
			S_AWT:    if (div_rsp.done) state_d = S_AX_MA;
			S_AX_MA:  state_d = S_AX_MB;
			S_AX_MB:  state_d = (ax_q == 2'd2) ? S_BASE_A : S_AX_CHK;
			S_BASE_A: state_d = S_BASE_B;
			S_BASE_B: state_d = S_SCAN;
			S_SCAN:   if (scan_last) state_d = S_DRAIN;
			S_DRAIN:  state_d = S_EMIT;
			S_EMIT:   if (out_take) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// Outputs of the sequencer: shared multiplier, divider, store read and input ready.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		ram_re = 1'b0;
		in_ch.ready = 1'b0;
		unique case (state_q)
			S_IDLE:   in_ch.ready = 1'b1;
			S_N12:    begin mul_a = MUL_W'(n_q[1]); mul_b = MUL_W'(n_q[2]); end
			S_TOT_A:  begin mul_a = MUL_W'(m_q[1]); mul_b = MUL_W'(m_q[2]); end
			S_TOT_B:  begin mul_a = MUL_W'(m_q[0]); mul_b = MUL_W'(m21_q); end
			S_WGO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(c_q);
				div_req.divisor  = m_q[2];
			end
			S_HGO: begin
				div_req.start    = 1'b1;
				div_req.dividend = DIV_W'(q1_q);
				div_req.divisor  = m_q[1];
			end
			S_AGO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {top, {FRAC_W{1'b0}}};
				div_req.divisor  = cur_m - 1'b1;
			end
			S_AX_MA: begin
				mul_a = {cur_o, {FRAC_W{1'b0}}} + MUL_W'(cur_u);
				mul_b = alpha_q;
			end
			S_AX_MB:  begin mul_a = MUL_W'(cur_u); mul_b = alpha_q; end
			S_BASE_A: begin mul_a = MUL_W'(st_q[0]); mul_b = MUL_W'(n12_q); end
			S_BASE_B: begin mul_a = MUL_W'(st_q[1]); mul_b = MUL_W'(n_q[2]); end
			S_SCAN:   ram_re = 1'b1;
			default:  ;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			n_q[0] <= 5'd16; n_q[1] <= 5'd16; n_q[2] <= 5'd16;
			m_q[0] <= 5'd8;  m_q[1] <= 5'd8;  m_q[2] <= 5'd8;
			win_q       <= 9'd73;
			float_q     <= 1'b0;
			frac_q[0] <= '0; frac_q[1] <= '0; frac_q[2] <= '0;
			load_cnt_q  <= '0;
			out_cnt_q   <= '0;
			ax_q        <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == S_SCAN);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IN_T:  n_q[0]  <= cfg_data[AXIS_W-1:0];
					CFG_IN_H:  n_q[1]  <= cfg_data[AXIS_W-1:0];
					CFG_IN_W:  n_q[2]  <= cfg_data[AXIS_W-1:0];
					CFG_OUT_T: m_q[0]  <= cfg_data[AXIS_W-1:0];
					CFG_OUT_H: m_q[1]  <= cfg_data[AXIS_W-1:0];
					CFG_OUT_W: m_q[2]  <= cfg_data[AXIS_W-1:0];
					CFG_WIN:   win_q   <= cfg_data;
					CFG_FLOAT: float_q <= cfg_data[0];
					default:   ;
				endcase
			end
			if (in_fire && in_ch.func == FUNC_FRAC) begin
				frac_q[0]  <= in_ch.sample_t;
				frac_q[1]  <= in_ch.sample_h;
				frac_q[2]  <= in_ch.sample_w;
				load_cnt_q <= '0;
				out_cnt_q  <= '0;
			end
			if (in_fire && in_ch.func == FUNC_LOAD) load_cnt_q <= load_cnt_q + 1'b1;
			if (state_q == S_HWT) ax_q <= '0;
			if ((state_q == S_AX_CHK && ax_bypass) || state_q == S_AX_MB) ax_q <= ax_q + 1'b1;
			if (state_q == S_EMIT && out_take) begin
				out_valid_q <= 1'b1;
				if (!invalid_q) begin
					out_cnt_q <= ({1'b0, c_q} + 1'b1 >= (IDX_W+1)'(total_q)) &&
						(TOT_W'(c_q) + 1'b1 >= total_q) ? '0 : c_q + 1'b1;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE:  invalid_q <= !ok;
			S_N12:   n12_q <= prod[N12_W-1:0];
			S_TOT_A: m21_q <= prod[N12_W-1:0];
			S_TOT_B: begin
				total_q <= prod[TOT_W-1:0];
				c_q <= (TOT_W'(out_cnt_q) >= prod[TOT_W-1:0]) ? '0 : out_cnt_q;
			end
			S_WWT: if (div_rsp.done) begin
				o_q[2] <= div_rsp.rem;
				q1_q   <= div_rsp.quot[IDX_W-1:0];
			end
			S_HWT: if (div_rsp.done) begin
				o_q[1] <= div_rsp.rem;
				o_q[0] <= div_rsp.quot[AXIS_W-1:0];
			end
			S_AX_CHK: if (ax_bypass) st_q[ax_q] <= top;
			S_AWT:   if (div_rsp.done) alpha_q <= div_rsp.quot;
			S_AX_MA: a_q <= hi;
			S_AX_MB: st_q[ax_q] <= (diff > HI_W'(top)) ? top : diff[AXIS_W-1:0];
			S_BASE_A: base_q <= prod[IDX_W-1:0];
			S_BASE_B: begin
				base_q     <= base_next;
				tbase_q    <= base_next;
				hbase_q    <= base_next;
				addr_q     <= base_next;
				kt_q <= '0; kh_q <= '0; kw_q <= '0;
				best_q     <= float_q ? FLOAT_LOWEST : INT_LOWEST;
				best_idx_q <= base_next;
				best_nan_q <= 1'b0;
			end
			S_SCAN: begin
				if (kw_q != km[2]) begin
					kw_q   <= kw_q + 1'b1;
					addr_q <= addr_q + 1'b1;
				end else if (kh_q != km[1]) begin
					kw_q    <= '0;
					kh_q    <= kh_q + 1'b1;
					hbase_q <= hbase_q + IDX_W'(n_q[2]);
					addr_q  <= hbase_q + IDX_W'(n_q[2]);
				end else begin
					kw_q    <= '0;
					kh_q    <= '0;
					kt_q    <= kt_q + 1'b1;
					tbase_q <= tbase_q + IDX_W'(n12_q);
					hbase_q <= tbase_q + IDX_W'(n12_q);
					addr_q  <= tbase_q + IDX_W'(n12_q);
				end
			end
			default: ;
		endcase
		idx_s1 <= addr_q;
		if (pend_s1 && take) begin
			best_q     <= rdata;
			best_idx_q <= idx_s1;
			best_nan_q <= float_q && f_is_nan(rdata);
		end
		if (state_q == S_EMIT && out_take) begin
			out_ch.max_value     <= invalid_q ? '0 : best_q;
			out_ch.max_index     <= invalid_q ? '0 : best_idx_q;
			out_ch.last_of_plane <= !invalid_q && (TOT_W'(c_q) + 1'b1 >= total_q);
			out_ch.status        <= invalid_q;
		end
	end

	assign out_ch.valid = out_valid_q;

	frp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	frp_ram #(
		.WIDTH (VAL_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (in_fire && in_ch.func == FUNC_LOAD),
		.waddr (load_cnt_q[AW-1:0]),
		.wdata (in_ch.voxel_value),
		.re    (ram_re),
		.raddr (addr_q[AW-1:0]),
		.rdata (rdata)
	);

	`FRP_ASSERT_IMP(a_pend_in_scan, pend_s1, state_q == S_SCAN || state_q == S_DRAIN)
	`FRP_ASSERT_IMP(a_div_free, div_req.start, !div_rsp.busy)
	`FRP_ASSERT_IMP(a_count_in_range, state_q == S_EMIT && !invalid_q,
		TOT_W'(c_q) < total_q)
	`FRP_ASSERT_IMP(a_status_zero_idx, out_ch.valid && out_ch.status,
		out_ch.max_index == '0 && !out_ch.last_of_plane)
	`FRP_ASSERT_NXT(a_scan_ends, state_q == S_SCAN && scan_last, state_q == S_DRAIN)
endmodule
`default_nettype wire
